// File: sv/tapc_pkg.sv
// ----------------------------------------------------------------------------
// tapc_pkg : shared types and helpers for the three-axis PID core
// Register map codes, lane sequencer states, lane interface structs and the
// sign, magnitude and saturation helpers used by the lanes.
// ----------------------------------------------------------------------------
package tapc_pkg;

   localparam int TAPC_MAX_AXES = 3;
   localparam int TAPC_AXES     = 3;

   localparam int DIV_STEPS = 64;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [31:0] PERIOD_RESET = 32'd65536;
   localparam logic [63:0] D_CLAMP      = 64'd1 << 48;

   localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
   localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

   // register indexes (byte address 4*index)
   localparam logic [1:0] REG_GAIN_P = 2'd0;
   localparam logic [1:0] REG_GAIN_I = 2'd1;
   localparam logic [1:0] REG_GAIN_D = 2'd2;
   localparam logic [1:0] REG_PERIOD = 2'd3;

   typedef enum logic [3:0] {
      LN_IDLE,
      LN_MUL_P,
      LN_MUL_T,
      LN_INTEG,
      LN_MUL_I,
      LN_MUL_D,
      LN_DIV,
      LN_SUM,
      LN_DONE
   } lane_state_type;

   typedef struct packed {
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic        [31:0] period;
   } tapc_cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } lane_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lane_stat_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      return v[32] ? 33'(-v) : 33'(v);
   endfunction

   function automatic logic signed [51:0] apply_sign(input logic [50:0] m, input logic neg);
      logic signed [51:0] ext;
      ext = $signed({1'b0, m});
      return neg ? -ext : ext;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      logic signed [31:0] res;
      if (v > SAT_MAX) begin
         res = 32'h7FFFFFFF;
      end else if (v < SAT_MIN) begin
         res = 32'h80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// File: sv/tapc_lane.sv
// ----------------------------------------------------------------------------
// tapc_lane : one PID axis
// Sequences a shared 33x32 multiplier over the P, trapezoid, I and D products,
// then a restoring divider, one quotient bit per cycle, for the D term.
// ----------------------------------------------------------------------------
module tapc_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  tapc_pkg::tapc_cfg_type    cfg,
   input  tapc_pkg::lane_ctrl_type   ctrl,
   input  logic signed [31:0]        err,
   output tapc_pkg::lane_stat_type   stat,
   output logic signed [31:0]        drive
);
   import tapc_pkg::*;

   lane_state_type state_ff, state_in;

   logic signed [31:0] err_ff;
   logic signed [31:0] prev_ff;
   logic signed [31:0] integ_ff;
   logic signed [47:0] p_ff;
   logic signed [47:0] i_ff;
   logic signed [31:0] drive_ff;
   logic        [63:0] prod_ff;
   logic        [31:0] rem_ff;
   logic   [CNT_W-1:0] cnt_ff;

   logic        [32:0] mul_a;
   logic        [31:0] mul_b;
   logic        [64:0] product_w;
   logic signed [32:0] sum_w;
   logic signed [32:0] diff_w;
   logic        [31:0] divisor_w;
   logic        [32:0] rem_sh_w;
   logic               qbit_w;
   logic        [31:0] rem_next_w;
   logic        [48:0] dmag_w;
   logic signed [51:0] integ_sum_w;
   logic signed [51:0] total_w;

   assign sum_w     = 33'(err_ff) + 33'(prev_ff);
   assign diff_w    = 33'(err_ff) - 33'(prev_ff);
   assign divisor_w = (cfg.period == '0) ? 32'd1 : cfg.period;
   assign product_w = 65'(mul_a) * 65'(mul_b);

   // restoring divide step
   assign rem_sh_w   = {rem_ff, prod_ff[63]};
   assign qbit_w     = rem_sh_w >= {1'b0, divisor_w};
   assign rem_next_w = qbit_w ? 32'(rem_sh_w - {1'b0, divisor_w}) : rem_sh_w[31:0];

   assign dmag_w = (prod_ff > D_CLAMP) ? D_CLAMP[48:0] : prod_ff[48:0];

   assign integ_sum_w = 52'(integ_ff)
                      + apply_sign({4'b0, prod_ff[63:17]}, sum_w[32]);
   assign total_w = 52'(p_ff) + 52'(i_ff)
                  + apply_sign({2'b0, dmag_w}, cfg.gain_d[31] ^ diff_w[32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         LN_IDLE: begin
            if (ctrl.start) state_in = LN_MUL_P;
         end
         LN_MUL_P: begin
            mul_a    = {1'b0, mag32(err_ff)};
            mul_b    = mag32(cfg.gain_p);
            state_in = LN_MUL_T;
         end
         LN_MUL_T: begin
            mul_a    = mag33(sum_w);
            mul_b    = cfg.period;
            state_in = LN_INTEG;
         end
         LN_INTEG: begin
            state_in = LN_MUL_I;
         end
         LN_MUL_I: begin
            mul_a    = {1'b0, mag32(integ_ff)};
            mul_b    = mag32(cfg.gain_i);
            state_in = LN_MUL_D;
         end
         LN_MUL_D: begin
            mul_a    = mag33(diff_w);
            mul_b    = mag32(cfg.gain_d);
            state_in = LN_DIV;
         end
         LN_DIV: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = LN_SUM;
         end
         LN_SUM: begin
            state_in = LN_DONE;
         end
         LN_DONE: begin
            if (ctrl.ack) state_in = LN_IDLE;
         end
         default: begin
            state_in = LN_IDLE;
         end
      endcase
   end

   // axis state: integral and last error
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         prev_ff  <= '0;
      end else begin
         if (state_ff == LN_INTEG) integ_ff <= sat32(integ_sum_w);
         if (state_ff == LN_SUM)   prev_ff  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         LN_IDLE: begin
            if (ctrl.start) err_ff <= err;
         end
         LN_MUL_P: begin
            prod_ff <= product_w[63:0];
         end
         LN_MUL_T: begin
            p_ff    <= 48'(apply_sign({3'b0, prod_ff[63:16]}, err_ff[31] ^ cfg.gain_p[31]));
            prod_ff <= product_w[63:0];
         end
         LN_MUL_I: begin
            prod_ff <= product_w[63:0];
         end
         LN_MUL_D: begin
            i_ff    <= 48'(apply_sign({3'b0, prod_ff[63:16]}, integ_ff[31] ^ cfg.gain_i[31]));
            prod_ff <= product_w[63:0];
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         LN_DIV: begin
            rem_ff  <= rem_next_w;
            prod_ff <= {prod_ff[62:0], qbit_w};
            cnt_ff  <= cnt_ff + CNT_W'(1);
         end
         LN_SUM: begin
            drive_ff <= sat32(total_w);
         end
         default: begin
         end
      endcase
   end

   assign stat.idle = (state_ff == LN_IDLE);
   assign stat.done = (state_ff == LN_DONE);
   assign drive     = drive_ff;

endmodule

// File: sv/three_axis_pid_controller_core.sv
// ----------------------------------------------------------------------------
// three_axis_pid_controller_core : three-axis PID step, Q16.16
// Each item steps every lane through the P and trapezoid products, the integral
// update, the I and D products, the bit-serial divider for the D term and the
// sum. A new item is taken once the previous result is in the output register.
// Reset (synchronous): gains zero, sample period 1.0, integrals and last errors
// zero, no result pending.
// ----------------------------------------------------------------------------
module three_axis_pid_controller_core #(
   parameter int AXES = tapc_pkg::TAPC_AXES
) (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_err_e12,
   input  logic signed [31:0] req_err_e31,
   input  logic signed [31:0] req_err_e23,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_e12,
   output logic signed [31:0] rsp_drive_e31,
   output logic signed [31:0] rsp_drive_e23,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import tapc_pkg::*;

   tapc_cfg_type  cfg_ff;
   lane_ctrl_type ctrl;
   lane_stat_type stat [TAPC_MAX_AXES];

   logic signed [31:0] err_w   [TAPC_MAX_AXES];
   logic signed [31:0] drive_w [TAPC_MAX_AXES];
   logic signed [31:0] out_ff  [TAPC_MAX_AXES];

   logic [TAPC_MAX_AXES-1:0] idle_w;
   logic [TAPC_MAX_AXES-1:0] done_w;
   logic                     rsp_valid_ff;
   logic                     out_load;
   logic [1:0]               reg_idx;
   logic                     cfg_write;

   // ---------------------------------------------------------------- config
   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p <= '0;
         cfg_ff.gain_i <= '0;
         cfg_ff.gain_d <= '0;
         cfg_ff.period <= PERIOD_RESET;
      end else if (cfg_write) begin
         case (reg_idx)
            REG_GAIN_P: cfg_ff.gain_p <= pwdata;
            REG_GAIN_I: cfg_ff.gain_i <= pwdata;
            REG_GAIN_D: cfg_ff.gain_d <= pwdata;
            REG_PERIOD: cfg_ff.period <= pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GAIN_P: prdata = cfg_ff.gain_p;
         REG_GAIN_I: prdata = cfg_ff.gain_i;
         REG_GAIN_D: prdata = cfg_ff.gain_d;
         REG_PERIOD: prdata = cfg_ff.period;
         default:    prdata = '0;
      endcase
   end

   // ----------------------------------------------------------------- lanes
   assign err_w[0] = req_err_e12;
   assign err_w[1] = req_err_e31;
   assign err_w[2] = req_err_e23;

   // all lanes run in lock step, so one start and one ack serve them all
   assign req_ready  = &idle_w;
   assign ctrl.start = req_valid && req_ready;
   assign ctrl.ack   = out_load;

   for (genvar k = 0; k < TAPC_MAX_AXES; k++) begin : g_lane
      if (k < AXES) begin : g_on
         tapc_lane u_lane (
            .clock (clock),
            .reset (reset),
            .cfg   (cfg_ff),
            .ctrl  (ctrl),
            .err   (err_w[k]),
            .stat  (stat[k]),
            .drive (drive_w[k])
         );
      end else begin : g_off
         // unused axis: always ready, always finished, drives zero
         assign stat[k].idle = 1'b1;
         assign stat[k].done = 1'b1;
         assign drive_w[k]   = '0;
      end
      assign idle_w[k] = stat[k].idle;
      assign done_w[k] = stat[k].done;
   end

   // ----------------------------------------------------------------- merge
   // Take the lanes' results into the output register once every lane has
   // finished and the register is empty or being drained; otherwise hold the
   // lanes in their finished state.
   assign out_load = (&done_w) && !(&idle_w) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= drive_w;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_e12 = out_ff[0];
   assign rsp_drive_e31 = out_ff[1];
   assign rsp_drive_e23 = out_ff[2];

   // ------------------------------------------------------------ assertions
   // lanes stay in step: all idle or none of the active ones
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      ($countones(idle_w) == TAPC_MAX_AXES) || ($countones(idle_w) == TAPC_MAX_AXES - AXES))
      else $error("lanes out of step");

   // an accepted item keeps the lanes busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready after accept");

   // a merged result frees the lanes at once
   a_free_after_merge: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (req_ready && rsp_valid))
      else $error("lanes not released after merge");

   // the output register empties only when drained
   a_drop_on_ready: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result dropped without handshake");

endmodule
